### design/bog_pkg.sv
// Shared constants for the broadcast offset generator.
package bog_pkg;

  localparam int IDX_BITS  = 32;
  localparam int SLOT_BITS = 16;
  localparam int CFG_BITS  = 64;
  localparam int CFG_IDX_BITS = 3;
  localparam int RANK_BITS = 3;
  localparam int MODE_BITS = 2;
  localparam int RED_BITS  = 16;
  localparam int OUT_DATA_BITS = 120;

  // Divider: four restoring steps per stage, eight stages per 32-bit dividend.
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES = IDX_BITS / STEPS_PER_STAGE;

  localparam logic [MODE_BITS-1:0] MODE_ELEM      = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_DOT       = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_COPY_SRC  = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_COPY_EDGE = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_OP_MODE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LHS_RANK = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RHS_RANK = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LHS_DIMS = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RHS_DIMS = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LHS_ROW  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RHS_ROW  = 3'd6;

endpackage

### design/broadcast_offset_generator.sv
// Broadcast offset generator: pipelined mixed-radix index split into operand offsets.
//
//  channel   dir  handshake                 word
//  s_*       in   s_tvalid / s_tready       out_index
//  m_*       out  m_tvalid / m_tready       offsets, flags, lengths
//  cfg_*     in   cfg_wr_en (no wait)       register index and data
//
// One word enters per cycle while s_tready is high. Per feature dimension, an
// eight-stage restoring divider (four quotient bits per stage) and one offset
// multiply-accumulate stage set the latency, plus the load register and the output
// register. Each stage holds its word when the next one is full, so bubbles fill and a
// stalled output loses and repeats nothing.
// Reset clears the valid bits and loads the register reset values; there is no
// clearing pass. Shape values derived from the registers settle after a write,
// before any word taken after the write can reach the stage that reads them.
module broadcast_offset_generator #(
  parameter int MAX_FEATURE_DIMS = 4,
  parameter int DIM_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [bog_pkg::IDX_BITS-1:0] s_tdata,        // [31:0] out_index
  output logic m_tvalid,
  input  logic m_tready,
  // [31:0] left operand offset, [63:32] right operand offset, [64] index_out_of_range,
  // [65] broadcasting, [97:66] output_length, [113:98] reduce_length, rest zero
  output logic [bog_pkg::OUT_DATA_BITS-1:0] m_tdata,
  input  logic cfg_wr_en,
  input  logic [bog_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bog_pkg::CFG_BITS-1:0] cfg_data
);
  import bog_pkg::*;

  localparam int F = MAX_FEATURE_DIMS;
  localparam int W = DIM_BITS;
  localparam int GRP = DIV_STAGES + 1;
  localparam int N_STG = 1 + GRP * F;

  typedef struct packed {
    logic [IDX_BITS-1:0] q;
    logic [W-1:0]        r;
  } div_t;

  function automatic div_t div_steps(logic [IDX_BITS-1:0] qi, logic [W-1:0] ri,
                                     logic [W-1:0] d);
    logic [IDX_BITS-1:0] qq;
    logic [W:0] t;
    logic [W-1:0] rr;
    div_t res;
    qq = qi;
    rr = ri;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      t  = {rr, qq[IDX_BITS-1]};
      qq = {qq[IDX_BITS-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        qq[0] = 1'b1;
      end
      rr = t[W-1:0];
    end
    res.q = qq;
    res.r = rr;
    return res;
  endfunction

  // Configuration registers
  logic [MODE_BITS-1:0] op_mode;
  logic [RANK_BITS-1:0] lhs_rank, rhs_rank;
  logic [CFG_BITS-1:0]  lhs_dims, rhs_dims;
  logic [IDX_BITS-1:0]  lhs_row_len, rhs_row_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode     <= MODE_ELEM;
      lhs_rank    <= RANK_BITS'(1);
      rhs_rank    <= RANK_BITS'(1);
      lhs_dims    <= '0;
      rhs_dims    <= '0;
      lhs_row_len <= '0;
      rhs_row_len <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OP_MODE:  op_mode     <= cfg_data[MODE_BITS-1:0];
        CFG_LHS_RANK: lhs_rank    <= cfg_data[RANK_BITS-1:0];
        CFG_RHS_RANK: rhs_rank    <= cfg_data[RANK_BITS-1:0];
        CFG_LHS_DIMS: lhs_dims    <= cfg_data;
        CFG_RHS_DIMS: rhs_dims    <= cfg_data;
        CFG_LHS_ROW:  lhs_row_len <= cfg_data[IDX_BITS-1:0];
        CFG_RHS_ROW:  rhs_row_len <= cfg_data[IDX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Shape decode from the registers
  localparam logic [RANK_BITS-1:0] RANK_MAX = RANK_BITS'(F + 1);
  localparam logic [W-1:0] ONE_W = W'(1);

  logic [RANK_BITS-1:0] cl, cr, maxd;
  logic c_dot, c_bcast, zero_c;
  logic [W-1:0] dl_c [F];
  logic [W-1:0] dr_c [F];
  logic [W-1:0] meff_c [F];
  logic [W-1:0] dle_c [F];
  logic [W-1:0] dre_c [F];
  logic [W-1:0] reduce_c;

  always_comb begin
    cl = (lhs_rank == '0) ? RANK_BITS'(1) : ((lhs_rank > RANK_MAX) ? RANK_MAX : lhs_rank);
    cr = (rhs_rank == '0) ? RANK_BITS'(1) : ((rhs_rank > RANK_MAX) ? RANK_MAX : rhs_rank);
    maxd  = ((cl > cr) ? cl : cr) - RANK_BITS'(1);
    c_dot = (op_mode == MODE_DOT);
    c_bcast = (cl != cr);
    zero_c = 1'b0;
    for (int j = 0; j < F; j++) begin
      dl_c[j] = (RANK_BITS'(j) + RANK_BITS'(1) >= cl) ? ONE_W
                                                      : lhs_dims[SLOT_BITS*j +: W];
      dr_c[j] = (RANK_BITS'(j) + RANK_BITS'(1) >= cr) ? ONE_W
                                                      : rhs_dims[SLOT_BITS*j +: W];
      if (dl_c[j] != dr_c[j]) c_bcast = 1'b1;
      // Dimensions outside the split behave as radix one
      if ((RANK_BITS'(j) < maxd) && !(c_dot && j == 0)) begin
        meff_c[j] = (dl_c[j] > dr_c[j]) ? dl_c[j] : dr_c[j];
        dle_c[j]  = dl_c[j];
        dre_c[j]  = dr_c[j];
      end else begin
        meff_c[j] = ONE_W;
        dle_c[j]  = ONE_W;
        dre_c[j]  = ONE_W;
      end
      if (meff_c[j] == '0) zero_c = 1'b1;
    end
    if (op_mode == MODE_COPY_SRC || op_mode == MODE_COPY_EDGE) c_bcast = 1'b0;
    reduce_c = (c_dot && cl >= RANK_BITS'(2)) ? dl_c[0] : ONE_W;
  end

  // Derived shape registers, refreshed every cycle
  logic sh_dot, sh_bcast, sh_zero;
  logic [W-1:0] sh_dl [F];
  logic [W-1:0] sh_dr [F];
  logic [W-1:0] sh_meff [F];
  logic [W-1:0] sh_dle [F];
  logic [W-1:0] sh_dre [F];
  logic [W-1:0] sh_reduce;
  logic [IDX_BITS-1:0] sh_base;
  logic [IDX_BITS-1:0] str_l [F];
  logic [IDX_BITS-1:0] str_r [F];
  logic [IDX_BITS:0] lenp [F+1];
  logic [IDX_BITS:0] blen;

  always_ff @(posedge clk) begin
    sh_dot    <= c_dot;
    sh_bcast  <= c_bcast;
    sh_reduce <= reduce_c;
    sh_base   <= (op_mode == MODE_COPY_EDGE) ? rhs_row_len : lhs_row_len;
    sh_zero   <= zero_c;
    for (int j = 0; j < F; j++) begin
      sh_dl[j]   <= dl_c[j];
      sh_dr[j]   <= dr_c[j];
      sh_meff[j] <= meff_c[j];
      sh_dle[j]  <= dle_c[j];
      sh_dre[j]  <= dre_c[j];
    end
  end

  // Strides and saturating length settle one dimension per cycle
  always_ff @(posedge clk) begin
    logic [IDX_BITS+W-1:0] p;
    lenp[0] <= (IDX_BITS+1)'(1);
    str_l[0] <= IDX_BITS'(1);
    str_r[0] <= IDX_BITS'(1);
    for (int j = 0; j < F; j++) begin
      p = lenp[j][IDX_BITS-1:0] * sh_meff[j];
      if (lenp[j][IDX_BITS] || p[IDX_BITS+W-1:IDX_BITS] != '0) begin
        lenp[j+1] <= {1'b1, {IDX_BITS{1'b0}}};
      end else begin
        lenp[j+1] <= {1'b0, p[IDX_BITS-1:0]};
      end
    end
    for (int j = 1; j < F; j++) begin
      str_l[j] <= IDX_BITS'(str_l[j-1] * sh_dle[j-1]);
      str_r[j] <= IDX_BITS'(str_r[j-1] * sh_dre[j-1]);
    end
    blen <= sh_zero ? '0 : lenp[F];
  end

  // Item pipeline
  logic                v   [N_STG+1];
  logic                rdy [N_STG+1];
  logic [IDX_BITS-1:0] idx [N_STG+1];
  logic [IDX_BITS-1:0] q   [N_STG+1];
  logic [W-1:0]        r   [N_STG+1];
  logic [IDX_BITS-1:0] rq  [N_STG+1];
  logic [W-1:0]        rr  [N_STG+1];
  logic [IDX_BITS-1:0] lo  [N_STG+1];
  logic [IDX_BITS-1:0] ro  [N_STG+1];

  for (genvar s = 0; s < N_STG; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end
  assign rdy[N_STG] = !v[N_STG] || m_tready;
  assign s_tready = rdy[0];

  // Load stage: hold the index as the first dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[0] && s_tvalid) begin
      idx[0] <= s_tdata;
      q[0]   <= s_tdata;
      r[0]   <= '0;
      rq[0]  <= '0;
      rr[0]  <= '0;
      lo[0]  <= '0;
      ro[0]  <= '0;
    end
  end

  for (genvar s = 1; s <= N_STG; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (rdy[s]) begin
        v[s] <= v[s-1];
      end
    end

    if (s < N_STG) begin : g_work
      localparam int G = (s - 1) / GRP;
      localparam int K = (s - 1) % GRP;
      div_t dn, rn;
      logic [IDX_BITS+W-1:0] pl, pr;

      always_comb begin
        dn = div_steps(q[s-1], r[s-1], sh_meff[G]);
        if (K == 0) rn = div_steps(sh_base, '0, sh_reduce);
        else        rn = div_steps(rq[s-1], rr[s-1], sh_reduce);
        pl = r[s-1] * str_l[G];
        pr = r[s-1] * str_r[G];
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && v[s-1]) begin
          idx[s] <= idx[s-1];
          if (K < DIV_STAGES) begin
            // Divide the running quotient by this dimension's radix
            q[s]  <= dn.q;
            r[s]  <= dn.r;
            lo[s] <= lo[s-1];
            ro[s] <= ro[s-1];
          end else begin
            // Add digit times stride where the digit lies inside the operand
            q[s]  <= q[s-1];
            r[s]  <= '0;
            lo[s] <= (r[s-1] < sh_dl[G]) ? lo[s-1] + pl[IDX_BITS-1:0] : lo[s-1];
            ro[s] <= (r[s-1] < sh_dr[G]) ? ro[s-1] + pr[IDX_BITS-1:0] : ro[s-1];
          end
          // Row length over reduce size runs alongside the first dimension
          if (G == 0 && K < DIV_STAGES) begin
            rq[s] <= rn.q;
            rr[s] <= rn.r;
          end else begin
            rq[s] <= rq[s-1];
            rr[s] <= rr[s-1];
          end
        end
      end
    end else begin : g_out
      logic [IDX_BITS-1:0] nb_len, o_len;
      logic oor;

      always_comb begin
        nb_len = sh_dot ? ((sh_reduce == '0) ? '0 : rq[s-1]) : sh_base;
        if (sh_bcast) begin
          oor   = ({1'b0, idx[s-1]} >= blen);
          o_len = blen[IDX_BITS] ? {IDX_BITS{1'b1}} : blen[IDX_BITS-1:0];
        end else begin
          oor   = (idx[s-1] >= nb_len);
          o_len = nb_len;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && v[s-1]) begin
          idx[s] <= idx[s-1];
          q[s]   <= q[s-1];
          r[s]   <= r[s-1];
          rq[s]  <= o_len;
          rr[s]  <= r[s-1];
          lo[s]  <= (sh_bcast && !oor) ? lo[s-1] : '0;
          ro[s]  <= (sh_bcast && !oor) ? ro[s-1] : '0;
          m_tdata <= {{(OUT_DATA_BITS - 3*IDX_BITS - 2 - RED_BITS){1'b0}},
                      RED_BITS'(sh_reduce), o_len, sh_bcast, oor,
                      ((sh_bcast && !oor) ? ro[s-1] : {IDX_BITS{1'b0}}),
                      ((sh_bcast && !oor) ? lo[s-1] : {IDX_BITS{1'b0}})};
        end
      end
    end
  end

  assign m_tvalid = v[N_STG];

endmodule
